### hw/rtl/arpr_pkg.sv
// shared types and constants for the arp responder and learner
// no dependencies; imported by every module of the block

package arpr_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MASK_W = 16;

  localparam int IN_DATA_W  = 264;
  localparam int OUT_DATA_W = 240;

  // item kinds carried on the input tuser
  localparam logic [1:0] KIND_ARP  = 2'd0;
  localparam logic [1:0] KIND_BIND = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // arp header constants
  localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
  localparam logic [7:0]  ARP_HLEN_ETH   = 8'd6;
  localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  ARP_PLEN_IPV4  = 8'd4;
  localparam logic [15:0] OP_REQUEST     = 16'd1;
  localparam logic [15:0] OP_REPLY       = 16'd2;

  // configuration register indexes
  localparam logic CFG_OWN_MAC = 1'b0;
  localparam logic CFG_OWN_IP  = 1'b1;

  typedef enum logic [2:0] {
    ST_REPLIED   = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_LEARNED   = 3'd2,
    ST_BAD_HW    = 3'd3,
    ST_BAD_PROTO = 3'd4,
    ST_BAD_OP    = 3'd5,
    ST_BOUND     = 3'd6,
    ST_READ      = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ_WAIT,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] hw_type;
    logic [7:0]  hw_len;
    logic [15:0] proto_type;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
    logic [3:0]  slot;
    logic [31:0] slot_ip;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] reply_opcode;
    logic [47:0] reply_sender_mac;
    logic [31:0] reply_sender_ip;
    logic [47:0] reply_target_mac;
    logic [31:0] reply_target_ip;
    logic [MASK_W-1:0] updated_mask;
    logic [47:0] read_mac;
  } result_t;

  typedef struct packed {
    logic              ip_we;
    logic              mac_we;
    logic [SLOT_W-1:0] wr_addr;
    logic [31:0]       ip_wdata;
    logic [47:0]       mac_wdata;
    logic [SLOT_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [31:0] ip_rdata;
    logic [47:0] mac_rdata;
  } mem_rsp_t;

endpackage

### hw/rtl/arpr_slot_mem.sv
// slot table storage: destination ip and destination mac per socket slot
// depends on arpr_pkg

module arpr_slot_mem (
  input  logic                clk,
  input  arpr_pkg::mem_req_t  req,
  output arpr_pkg::mem_rsp_t  rsp
);
  import arpr_pkg::*;

  logic [31:0] ip_mem  [SLOTS];
  logic [47:0] mac_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (req.ip_we) begin
      ip_mem[req.wr_addr] <= req.ip_wdata;
    end
    if (req.mac_we) begin
      mac_mem[req.wr_addr] <= req.mac_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rsp.ip_rdata  <= ip_mem[req.rd_addr];
    rsp.mac_rdata <= mac_mem[req.rd_addr];
  end

endmodule

### hw/rtl/arpr_ctrl.sv
// item sequencer: header checks, reply build, slot bind, read and learn scan
// depends on arpr_pkg; drives arpr_slot_mem through mem_req_t

module arpr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  arpr_pkg::item_t    in_item,
  input  logic [47:0]        own_mac,
  input  logic [31:0]        own_ip,
  output arpr_pkg::mem_req_t mem_req,
  input  arpr_pkg::mem_rsp_t mem_rsp,
  input  logic               out_free,
  output logic               done,
  output arpr_pkg::result_t  res
);
  import arpr_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  state_t            state;
  state_t            state_next;
  item_t             item;
  logic [SLOT_W-1:0] cnt;
  logic              chk_valid;
  logic [SLOT_W-1:0] chk_idx;
  logic [SLOTS-1:0]  slot_valid;
  logic [SLOTS-1:0]  mac_written;

  logic [SLOT_W-1:0] slot_idx;
  logic              slot_ok;
  logic              hw_ok;
  logic              proto_ok;
  status_t           arp_status;
  status_t           check_status;
  logic              learn_hit;

  // decode of the captured item
  always_comb begin
    slot_idx = SLOT_W'(item.slot);
    slot_ok  = int'(item.slot) < SLOTS;
    hw_ok    = (item.hw_type == ARP_HTYPE_ETH) && (item.hw_len == ARP_HLEN_ETH);
    proto_ok = (item.proto_type == ARP_PTYPE_IPV4) && (item.proto_len == ARP_PLEN_IPV4);
    priority if (!hw_ok) begin
      arp_status = ST_BAD_HW;
    end else if (!proto_ok) begin
      arp_status = ST_BAD_PROTO;
    end else if (item.opcode == OP_REQUEST) begin
      arp_status = (item.target_ip == own_ip) ? ST_REPLIED : ST_IGNORED;
    end else if (item.opcode == OP_REPLY) begin
      arp_status = ST_LEARNED;
    end else begin
      arp_status = ST_BAD_OP;
    end
    unique case (item.kind)
      KIND_ARP:  check_status = arp_status;
      KIND_BIND: check_status = slot_ok ? ST_BOUND : ST_IGNORED;
      KIND_READ: check_status = ST_READ;
      default:   check_status = ST_IGNORED;
    endcase
  end

  // slot whose read data is back this cycle matches the reply sender
  assign learn_hit = chk_valid && slot_valid[chk_idx] && (mem_rsp.ip_rdata == item.sender_ip);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (item.kind == KIND_READ) begin
          state_next = S_READ_WAIT;
        end else if (check_status == ST_LEARNED) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_READ_WAIT: state_next = S_FINISH;
      S_SCAN:      if (cnt == LAST_SLOT) state_next = S_DRAIN;
      S_DRAIN:     state_next = S_FINISH;
      S_FINISH:    if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready          = (state == S_IDLE);
    done              = (state == S_FINISH) && out_free;
    mem_req.ip_we     = (state == S_CHECK) && (check_status == ST_BOUND);
    mem_req.mac_we    = learn_hit;
    mem_req.wr_addr   = mem_req.ip_we ? slot_idx : chk_idx;
    mem_req.ip_wdata  = item.slot_ip;
    mem_req.mac_wdata = item.sender_mac;
    mem_req.rd_addr   = (state == S_SCAN) ? cnt : slot_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      chk_valid   <= 1'b0;
      slot_valid  <= '0;
      mac_written <= '0;
    end else begin
      state     <= state_next;
      chk_valid <= (state == S_SCAN);
      if (mem_req.ip_we) begin
        slot_valid[slot_idx] <= 1'b1;
      end
      if (mem_req.mac_we) begin
        mac_written[chk_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= cnt;
    if (in_valid && in_ready) begin
      item <= in_item;
      res  <= '0;
    end
    if (state == S_CHECK) begin
      cnt        <= '0;
      res.status <= check_status;
      if (check_status == ST_REPLIED) begin
        res.reply_opcode     <= OP_REPLY;
        res.reply_sender_mac <= own_mac;
        res.reply_sender_ip  <= own_ip;
        res.reply_target_mac <= item.sender_mac;
        res.reply_target_ip  <= item.sender_ip;
      end
    end
    if (state == S_SCAN) begin
      cnt <= cnt + SLOT_W'(1);
    end
    if (learn_hit && (int'(chk_idx) < MASK_W)) begin
      res.updated_mask <= res.updated_mask | (MASK_W'(1) << chk_idx);
    end
    if (state == S_READ_WAIT) begin
      res.read_mac <= (slot_ok && mac_written[slot_idx]) ? mem_rsp.mac_rdata : '0;
    end
  end

  // learn writes only come from a scan read that just returned
  a_mac_we_in_scan: assert property (@(posedge clk) disable iff (rst)
    mem_req.mac_we |-> ((state == S_SCAN) || (state == S_DRAIN)))
    else $error("mac write outside learn scan");

  // a result is only handed over when the output stage can take it
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> out_free)
    else $error("result handed over to a full output stage");

  // only a learn result carries an update mask
  a_mask_learn: assert property (@(posedge clk) disable iff (rst)
    (done && (res.status != ST_LEARNED)) |-> (res.updated_mask == '0))
    else $error("update mask on a non-learn result");

  // read data is sampled in the cycle after the read address was set
  a_read_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ_WAIT) |-> ($past(state) == S_CHECK))
    else $error("read wait not preceded by check");

endmodule

### hw/rtl/arp_responder_and_learner.sv
// top level of the arp responder and learner: stream ports, config registers,
// result output stage; depends on arpr_pkg, arpr_slot_mem and arpr_ctrl

// One beat in, one beat out. An ARP packet beat (kind 0) has its header
// checked (hardware type 1 / length 6, protocol 0x0800 / length 4); a request
// for own_ip yields a reply in the result, a reply beat updates the MAC of
// every bound slot whose destination IP equals the sender IP and reports
// them in updated_mask. Kind 1 binds a slot's destination IP, kind 2 reads a
// slot's MAC. Items are handled one at a time, and a learn runs a scan that
// reads the slot table one entry per cycle through its single read port. A
// finished result sits in the output stage, so the next beat is accepted
// while it waits for tready. After reset all slots read as unbound with a
// zero MAC at once; there is no clearing pass. own_mac / own_ip should be
// written only while idle.

module arp_responder_and_learner (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [47:0]                        cfg_data,
  // input beats
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // hw_type, hw_len, proto_type, proto_len, opcode, sender_mac, sender_ip,
  // target_mac, target_ip, slot, slot_ip, zero pad
  input  logic [arpr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind
  input  logic [1:0]                         s_axis_tuser,
  // result beats
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // reply_opcode, reply_sender_mac, reply_sender_ip, reply_target_mac,
  // reply_target_ip, updated_mask, read_mac
  output logic [arpr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status
  output logic [2:0]                         m_axis_tuser
);
  import arpr_pkg::*;

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  item_t       in_item;
  mem_req_t    mem_req;
  mem_rsp_t    mem_rsp;
  logic        out_free;
  logic        done;
  result_t     res;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      own_ip  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_MAC: own_mac <= cfg_data;
        CFG_OWN_IP:  own_ip  <= cfg_data[31:0];
        default:     ;
      endcase
    end
  end

  // unpack the input beat, lowest field first
  always_comb begin
    in_item.kind       = s_axis_tuser;
    in_item.hw_type    = s_axis_tdata[15:0];
    in_item.hw_len     = s_axis_tdata[23:16];
    in_item.proto_type = s_axis_tdata[39:24];
    in_item.proto_len  = s_axis_tdata[47:40];
    in_item.opcode     = s_axis_tdata[63:48];
    in_item.sender_mac = s_axis_tdata[111:64];
    in_item.sender_ip  = s_axis_tdata[143:112];
    in_item.target_mac = s_axis_tdata[191:144];
    in_item.target_ip  = s_axis_tdata[223:192];
    in_item.slot       = s_axis_tdata[227:224];
    in_item.slot_ip    = s_axis_tdata[259:228];
  end

  arpr_slot_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  arpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .own_mac  (own_mac),
    .own_ip   (own_ip),
    .mem_req  (mem_req),
    .mem_rsp  (mem_rsp),
    .out_free (out_free),
    .done     (done),
    .res      (res)
  );

  // output stage: holds one result until the sink takes it
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_axis_tuser  <= res.status;
      m_axis_tdata  <= {res.read_mac, res.updated_mask, res.reply_target_ip,
                        res.reply_target_mac, res.reply_sender_ip,
                        res.reply_sender_mac, res.reply_opcode};
    end
  end

endmodule

### test/arp_responder_and_learner_checker.sv
// watches the config, input and result channels of the arp responder and learner,
// predicts each result from its own copy of station and slot state and compares
// depends on arpr_pkg

module arp_responder_and_learner_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [47:0]                       cfg_data,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [arpr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic [1:0]                        s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [arpr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic [2:0]                        m_axis_tuser,
  output int                                failures,
  output int                                outstanding
);
  import arpr_pkg::*;

  logic [47:0] station_mac;
  logic [31:0] station_ip;
  logic [31:0] bound_ip [SLOTS];
  logic [47:0] learned_mac [SLOTS];
  logic        bound [SLOTS];

  result_t     pending_results [$];

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  // advances the slot table by one item and gives the result it yields
  function automatic result_t arp_outcome(input item_t it);
    result_t r;
    r = '0;
    case (it.kind)
      KIND_ARP: begin
        if (it.hw_type != ARP_HTYPE_ETH || it.hw_len != ARP_HLEN_ETH) begin
          r.status = ST_BAD_HW;
        end else if (it.proto_type != ARP_PTYPE_IPV4 || it.proto_len != ARP_PLEN_IPV4) begin
          r.status = ST_BAD_PROTO;
        end else if (it.opcode == OP_REQUEST) begin
          if (it.target_ip != station_ip) begin
            r.status = ST_IGNORED;
          end else begin
            r.status           = ST_REPLIED;
            r.reply_opcode     = OP_REPLY;
            r.reply_sender_mac = station_mac;
            r.reply_sender_ip  = station_ip;
            r.reply_target_mac = it.sender_mac;
            r.reply_target_ip  = it.sender_ip;
          end
        end else if (it.opcode == OP_REPLY) begin
          r.status = ST_LEARNED;
          for (int i = 0; i < SLOTS; i++) begin
            if (bound[i] && bound_ip[i] == it.sender_ip) begin
              learned_mac[i] = it.sender_mac;
              if (i < MASK_W) r.updated_mask[i] = 1'b1;
            end
          end
        end else begin
          r.status = ST_BAD_OP;
        end
      end
      KIND_BIND: begin
        if (int'(it.slot) < SLOTS) begin
          bound_ip[it.slot] = it.slot_ip;
          bound[it.slot]    = 1'b1;
          r.status          = ST_BOUND;
        end else begin
          r.status = ST_IGNORED;
        end
      end
      KIND_READ: begin
        r.status = ST_READ;
        if (int'(it.slot) < SLOTS) r.read_mac = learned_mac[it.slot];
      end
      default: r.status = ST_IGNORED;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
    if (want !== got) begin
      if (failures < 10)
        $display("result mismatch on %s: expected %h, got %h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    item_t   seen;
    result_t want;
    if (rst) begin
      station_mac = '0;
      station_ip  = '0;
      for (int i = 0; i < SLOTS; i++) begin
        bound_ip[i]    = '0;
        learned_mac[i] = '0;
        bound[i]       = 1'b0;
      end
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OWN_MAC) station_mac = cfg_data;
        else                          station_ip  = cfg_data[31:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          if (failures < 10)
            $display("result beat with nothing expected: status %0d", m_axis_tuser);
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 48'(want.status), 48'(m_axis_tuser));
          check_field("reply_opcode", 48'(want.reply_opcode), 48'(m_axis_tdata[15:0]));
          check_field("reply_sender_mac", want.reply_sender_mac, m_axis_tdata[63:16]);
          check_field("reply_sender_ip", 48'(want.reply_sender_ip), 48'(m_axis_tdata[95:64]));
          check_field("reply_target_mac", want.reply_target_mac, m_axis_tdata[143:96]);
          check_field("reply_target_ip", 48'(want.reply_target_ip),
                      48'(m_axis_tdata[175:144]));
          check_field("updated_mask", 48'(want.updated_mask), 48'(m_axis_tdata[191:176]));
          check_field("read_mac", want.read_mac, m_axis_tdata[239:192]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen.kind       = s_axis_tuser;
        seen.hw_type    = s_axis_tdata[15:0];
        seen.hw_len     = s_axis_tdata[23:16];
        seen.proto_type = s_axis_tdata[39:24];
        seen.proto_len  = s_axis_tdata[47:40];
        seen.opcode     = s_axis_tdata[63:48];
        seen.sender_mac = s_axis_tdata[111:64];
        seen.sender_ip  = s_axis_tdata[143:112];
        seen.target_mac = s_axis_tdata[191:144];
        seen.target_ip  = s_axis_tdata[223:192];
        seen.slot       = s_axis_tdata[227:224];
        seen.slot_ip    = s_axis_tdata[259:228];
        pending_results.push_back(arp_outcome(seen));
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

### test/arp_responder_and_learner_tb.sv
// top of the arp responder and learner testbench: clock, reset, stimulus and verdict
// depends on arpr_pkg, arp_responder_and_learner and arp_responder_and_learner_checker

module arp_responder_and_learner_tb;
  import arpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 206;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = 1'b0;
  logic [47:0]            cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // hw_type, hw_len, proto_type, proto_len, opcode, sender_mac, sender_ip,
  // target_mac, target_ip, slot, slot_ip, zero pad
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  // kind
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // reply_opcode, reply_sender_mac, reply_sender_ip, reply_target_mac,
  // reply_target_ip, updated_mask, read_mac
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  // status
  logic [2:0]             m_axis_tuser;

  int failures;
  int outstanding;

  // station address as last written, and the addresses random packets draw from
  logic [31:0] station_ip;
  logic [31:0] ip_pool [6];

  int burst_left = 0;
  bit stall_output = 1'b0;

  arp_responder_and_learner i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  arp_responder_and_learner_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .failures      (failures),
    .outstanding   (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // well-formed ethernet / ipv4 packet with the given addresses
  function automatic item_t arp_packet(input logic [15:0] op, input logic [47:0] smac,
                                       input logic [31:0] sip, input logic [47:0] tmac,
                                       input logic [31:0] tip);
    item_t it;
    it.kind       = KIND_ARP;
    it.hw_type    = ARP_HTYPE_ETH;
    it.hw_len     = ARP_HLEN_ETH;
    it.proto_type = ARP_PTYPE_IPV4;
    it.proto_len  = ARP_PLEN_IPV4;
    it.opcode     = op;
    it.sender_mac = smac;
    it.sender_ip  = sip;
    it.target_mac = tmac;
    it.target_ip  = tip;
    it.slot       = 4'($urandom);
    it.slot_ip    = $urandom;
    return it;
  endfunction

  // bind and read items: the arp fields are don't-care and carry noise
  function automatic item_t slot_item(input logic [1:0] kind, input logic [3:0] slot,
                                      input logic [31:0] ip);
    item_t it;
    it         = arp_packet(16'($urandom), rand48(), $urandom, rand48(), $urandom);
    it.kind    = kind;
    it.slot    = slot;
    it.slot_ip = ip;
    return it;
  endfunction

  function automatic logic [31:0] pool_ip();
    return ip_pool[$urandom_range(0, 5)];
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    it   = arp_packet(16'($urandom), rand48(), $urandom, rand48(), $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // request, mostly for this station
      it.opcode = OP_REQUEST;
      it.target_ip = ($urandom_range(0, 4) != 0) ? station_ip : pool_ip();
    end else if (pick < 55) begin
      // reply, mostly from an address some slot may be bound to
      it.opcode = OP_REPLY;
      if ($urandom_range(0, 4) != 0) it.sender_ip = pool_ip();
    end else if (pick < 70) begin
      it = slot_item(KIND_BIND, 4'($urandom), ($urandom_range(0, 4) != 0) ? pool_ip() : $urandom);
    end else if (pick < 80) begin
      it = slot_item(KIND_READ, 4'($urandom), $urandom);
    end else if (pick < 90) begin
      // broken header, mostly one field at a time so the check order gets exercised
      it.opcode = ($urandom_range(0, 1) != 0) ? OP_REQUEST : OP_REPLY;
      case ($urandom_range(0, 4))
        0: it.hw_type    = 16'($urandom);
        1: it.hw_len     = 8'($urandom);
        2: it.proto_type = 16'($urandom);
        3: it.proto_len  = 8'($urandom);
        default: begin
          it.hw_type    = 16'($urandom);
          it.hw_len     = 8'($urandom);
          it.proto_type = 16'($urandom);
          it.proto_len  = 8'($urandom);
        end
      endcase
    end else if (pick >= 95) begin
      // pure noise, including the unused kind
      it.kind       = 2'($urandom);
      it.hw_type    = 16'($urandom);
      it.hw_len     = 8'($urandom);
      it.proto_type = 16'($urandom);
      it.proto_len  = 8'($urandom);
    end
    return it;
  endfunction

  // offers one beat; called at a clock edge, returns at the edge that takes it.
  // valid is only lowered when a gap really follows, so it never gets two
  // assignments in one step
  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {4'b0, it.slot_ip, it.slot, it.target_ip, it.target_mac, it.sender_ip,
                      it.sender_mac, it.opcode, it.proto_len, it.proto_type, it.hw_len,
                      it.hw_type};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // writes both station registers back to back, only while the block is idle;
  // the ip word carries junk in its upper bits, which the block must drop
  task automatic set_station(input logic [47:0] mac, input logic [47:0] ip_word);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_OWN_MAC;
    cfg_data  <= mac;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_OWN_IP;
    cfg_data  <= ip_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    station_ip = ip_word[31:0];
    ip_pool[0] = station_ip;
    ip_pool[1] = 32'h0;
    ip_pool[2] = 32'hFFFF_FFFF;
    for (int i = 3; i < 6; i++) ip_pool[i] = $urandom;
  endtask

  // receiver: ready follows a randomly drawn pattern that is replaced whenever it runs out,
  // with a long hold-off on request so the block backs up into its input
  initial begin
    int mode;
    int mode_left;
    mode_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (stall_output) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        stall_output = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) != 0);
          2: m_axis_tready <= ($urandom_range(0, 9) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ends the run when no beat moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[arp_responder_and_learner] ERROR");
    $finish;
  end

  initial begin
    logic [31:0] ip_a;
    ip_a = 32'h0A00_0001;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // slot table straight out of reset reads zero, station address is zero
    send_item(slot_item(KIND_READ, 4'd0, $urandom));
    send_item(arp_packet(OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'h0, '0, 32'h0));
    drain();

    // directed part with the station at all ones
    set_station(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(arp_packet(OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF));
    send_item(arp_packet(OP_REQUEST, '0, 32'h0, 48'hFFFF_FFFF_FFFF, 32'h0));
    begin
      item_t it;
      // header checks: hardware before protocol, then the opcode
      it = arp_packet(OP_REQUEST, rand48(), $urandom, rand48(), 32'hFFFF_FFFF);
      it.hw_type = 16'hFFFF;
      send_item(it);
      it = arp_packet(OP_REQUEST, rand48(), $urandom, rand48(), 32'hFFFF_FFFF);
      it.hw_len = 8'hFF;
      send_item(it);
      it = arp_packet(OP_REPLY, rand48(), $urandom, rand48(), $urandom);
      it.hw_type    = 16'h0000;
      it.proto_type = 16'h0000;
      send_item(it);
      it = arp_packet(OP_REQUEST, rand48(), $urandom, rand48(), 32'hFFFF_FFFF);
      it.proto_type = 16'h86DD;
      send_item(it);
      it = arp_packet(OP_REPLY, rand48(), $urandom, rand48(), $urandom);
      it.proto_len = 8'd16;
      send_item(it);
      send_item(arp_packet(16'h0000, rand48(), $urandom, rand48(), 32'hFFFF_FFFF));
      send_item(arp_packet(16'hFFFF, rand48(), $urandom, rand48(), 32'hFFFF_FFFF));
      send_item(arp_packet(16'h0003, rand48(), $urandom, rand48(), 32'hFFFF_FFFF));
      // bind a few slots, two of them to the same address
      send_item(slot_item(KIND_BIND, 4'd0, ip_a));
      send_item(slot_item(KIND_BIND, 4'd15, 32'hFFFF_FFFF));
      send_item(slot_item(KIND_BIND, 4'd3, ip_a));
      send_item(slot_item(KIND_BIND, 4'd7, 32'h0));
      // learning: two slots at once, single slots, and no slot at all
      send_item(arp_packet(OP_REPLY, 48'hFFFF_FFFF_FFFF, ip_a, '0, $urandom));
      send_item(arp_packet(OP_REPLY, 48'h0000_0000_0001, 32'h0, '0, $urandom));
      send_item(arp_packet(OP_REPLY, rand48(), 32'h1234_5678, '0, $urandom));
      send_item(arp_packet(OP_REPLY, 48'h8000_0000_0000, 32'hFFFF_FFFF, '0, $urandom));
      send_item(slot_item(KIND_READ, 4'd0, $urandom));
      send_item(slot_item(KIND_READ, 4'd15, $urandom));
      send_item(slot_item(KIND_READ, 4'd3, $urandom));
      // unused kind is ignored
      it = arp_packet(OP_REPLY, rand48(), ip_a, rand48(), $urandom);
      it.kind = 2'd3;
      send_item(it);
      // rebinding keeps the learned mac
      send_item(slot_item(KIND_BIND, 4'd0, 32'h0A00_0002));
      send_item(slot_item(KIND_READ, 4'd0, $urandom));
    end
    drain();

    // random phases, each under its own station address
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_station(48'h0, {16'($urandom), 32'h0});
        1: set_station(rand48(), rand48());
        2: set_station(48'h0000_0000_0001, {16'hFFFF, 32'h0000_0001});
        default: set_station(rand48(), rand48());
      endcase
      // back the block up once while the sender keeps pushing
      if (phase == 1) stall_output = 1'b1;
      repeat (RANDOM_PER_PHASE) send_item(random_item());
      drain();
    end

    // let anything stray come out before the verdict
    repeat (40) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("[arp_responder_and_learner] OK");
    else
      $display("[arp_responder_and_learner] ERROR");
    $finish;
  end

endmodule

### sim.f
hw/rtl/arpr_pkg.sv
hw/rtl/arpr_slot_mem.sv
hw/rtl/arpr_ctrl.sv
hw/rtl/arp_responder_and_learner.sv
test/arp_responder_and_learner_checker.sv
test/arp_responder_and_learner_tb.sv
